// ===== src/cit_pkg.sv =====
`default_nettype none
package cit_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Stream widths
  localparam int IN_DATA_W  = 40;  // entry_key, data_byte
  localparam int IN_USER_W  = 5;   // operation, file_kind, has_byte
  localparam int OUT_DATA_W = 72;  // expected_crc, calculated_crc, cleared_count, pad
  localparam int OUT_USER_W = 3;   // status

  localparam int CRC_W  = 32;
  localparam int REF_W  = 3 * CRC_W;
  localparam int COUNT_W = 7;

  localparam logic [CRC_W-1:0]   CRC_POLY  = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]   CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // File kinds (code 3 selects no field)
  localparam logic [1:0] KIND_PLAYER  = 2'd0;
  localparam logic [1:0] KIND_TEXTOBJ = 2'd1;
  localparam logic [1:0] KIND_TIMEOBJ = 2'd2;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_VERIFY = 2'd1,
    OP_RESET  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_BASELINE   = 3'd1,
    ST_MATCH      = 3'd2,
    ST_MISMATCH   = 3'd3,
    ST_RESET_DONE = 3'd4,
    ST_CLEARED    = 3'd5,
    ST_FULL       = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_APPLY,
    S_EMIT
  } state_t;

  // Fold one byte into a reflected CRC-32
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/crc32_integrity_table.sv =====
// crc32_integrity_table
//
// Input stream (s_axis): one word per buffer byte. tdata carries the entry key
// and the byte, tuser the operation, file kind and a has-byte flag, tlast
// marks the final word of a buffer. Words without tlast fold their byte (if
// has_byte is set) into a reflected CRC-32 and are taken one per cycle while
// the sequencer is idle. The word with tlast starts the table action. A shared
// key compare unit walks all TABLE_DEPTH entries, one key memory read per
// cycle, then the reference word of the selected entry is read, updated and
// written back. s_axis_tready is low from the accept of a last word until its
// result is moved into the output register.
// Result stream (m_axis): one word per buffer, held in an output register.
// While it stalls and the sequencer is idle, plain byte words are still
// accepted; a later last word waits in the sequencer until the output
// register is free.
// Reset clears the CRC to all ones, empties the table (valid bits cleared at
// once, no clearing pass) and drops any pending result.
`default_nettype none
module crc32_integrity_table (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // [31:0] entry_key, [39:32] data_byte
  input  wire logic [cit_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] operation, [3:2] file_kind, [4] has_byte
  input  wire logic [cit_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] expected_crc, [63:32] calculated_crc, [70:64] cleared_count, [71] zero
  output      logic [cit_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [2:0] status
  output      logic [cit_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import cit_pkg::*;

  state_t state, state_next;

  // Input field views
  logic [CRC_W-1:0] in_key;
  logic [7:0]       in_byte;
  op_t              in_op;
  logic [1:0]       in_kind;
  logic             in_has;
  logic             in_word;

  assign in_key  = s_axis_tdata[31:0];
  assign in_byte = s_axis_tdata[39:32];
  assign in_op   = op_t'(s_axis_tuser[1:0]);
  assign in_kind = s_axis_tuser[3:2];
  assign in_has  = s_axis_tuser[4];
  assign in_word = s_axis_tvalid & s_axis_tready;

  // Running CRC and captured item
  logic [CRC_W-1:0] running_crc;
  logic [CRC_W-1:0] crc_folded;
  logic [CRC_W-1:0] crc_final;
  op_t              op_q;
  logic [CRC_W-1:0] key_q;
  logic [1:0]       kind_q;

  // Table storage
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [CRC_W-1:0]       key_mem [TABLE_DEPTH];
  logic [REF_W-1:0]       ref_mem [TABLE_DEPTH];
  logic [CRC_W-1:0]       key_rd;
  logic [REF_W-1:0]       ref_rd;

  // Scan sequencer
  logic [CNT_W-1:0]   scan_cnt;
  logic               scan_end;
  logic [IDX_W-1:0]   cmp_idx;
  logic               cmp_vld;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;
  logic [COUNT_W-1:0] vcount;
  logic [IDX_W-1:0]   sel_idx;

  // Control from the sequencer
  logic scan_issue;
  logic apply_en;
  logic emit_en;
  logic out_free;

  // Apply-stage results
  logic [REF_W-1:0]   stored_word;
  logic [CRC_W-1:0]   stored_fld;
  logic [REF_W-1:0]   new_word;
  logic [CRC_W-1:0]   wval;
  logic               do_write;
  logic               do_insert;
  logic               do_clear;
  status_t            res_status_c;
  logic [CRC_W-1:0]   res_exp_c;
  logic [CRC_W-1:0]   res_calc_c;
  logic [COUNT_W-1:0] res_cnt_c;

  status_t            res_status;
  logic [CRC_W-1:0]   res_exp;
  logic [CRC_W-1:0]   res_calc;
  logic [COUNT_W-1:0] res_cnt;

  assign crc_folded = in_has ? crc_byte(running_crc, in_byte) : running_crc;
  assign crc_final  = crc_folded ^ CRC_ONES;
  assign scan_end   = (scan_cnt == CNT_W'(TABLE_DEPTH));
  assign sel_idx    = hit ? hit_idx : free_idx;
  assign out_free   = ~m_axis_tvalid | m_axis_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_word && s_axis_tlast) state_next = S_SCAN;
      S_SCAN:  if (scan_end && !cmp_vld) state_next = S_FETCH;
      S_FETCH: state_next = S_APPLY;
      S_APPLY: state_next = S_EMIT;
      S_EMIT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    scan_issue    = 1'b0;
    apply_en      = 1'b0;
    emit_en       = 1'b0;
    unique case (state)
      S_IDLE:  s_axis_tready = 1'b1;
      S_SCAN:  scan_issue    = ~scan_end;
      S_FETCH: ;
      S_APPLY: apply_en      = 1'b1;
      S_EMIT:  emit_en       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fold bytes; capture the last word and restart the CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_ONES;
    end else if (in_word) begin
      running_crc <= s_axis_tlast ? CRC_ONES : crc_folded;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word && s_axis_tlast) begin
      op_q     <= in_op;
      key_q    <= in_key;
      kind_q   <= in_kind;
    end
  end

  // Walk the key memory: issue one address per cycle, compare in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      cmp_vld  <= 1'b0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
      vcount   <= '0;
    end else if (in_word && s_axis_tlast) begin
      scan_cnt <= '0;
      cmp_vld  <= 1'b0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
      vcount   <= '0;
    end else begin
      cmp_vld <= scan_issue;
      if (scan_issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      if (cmp_vld) begin
        if (entry_valid[cmp_idx]) begin
          if (vcount != COUNT_MAX) vcount <= vcount + COUNT_W'(1);
          if (!hit && key_rd == key_q) hit <= 1'b1;
        end else if (!free_ok) begin
          free_ok <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_cnt[IDX_W-1:0];
    if (cmp_vld) begin
      if (entry_valid[cmp_idx] && !hit && key_rd == key_q) hit_idx <= cmp_idx;
      if (!entry_valid[cmp_idx] && !free_ok) free_idx <= cmp_idx;
    end
  end

  // Key and reference memories
  always_ff @(posedge clk) begin
    key_rd <= key_mem[scan_cnt[IDX_W-1:0]];
    ref_rd <= ref_mem[sel_idx];
    if (do_insert) key_mem[sel_idx] <= key_q;
    if (do_write)  ref_mem[sel_idx] <= new_word;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (do_clear) begin
      entry_valid <= '0;
    end else if (do_insert) begin
      entry_valid[sel_idx] <= 1'b1;
    end
  end

  // Decide the table action for the captured item
  always_comb begin
    stored_word  = hit ? ref_rd : '0;
    stored_fld   = '0;
    wval         = '0;
    do_write     = 1'b0;
    do_insert    = 1'b0;
    do_clear     = 1'b0;
    res_status_c = ST_STORED;
    res_exp_c    = '0;
    res_calc_c   = '0;
    res_cnt_c    = '0;

    unique case (kind_q)
      KIND_PLAYER:  stored_fld = stored_word[CRC_W-1:0];
      KIND_TEXTOBJ: stored_fld = stored_word[2*CRC_W-1:CRC_W];
      KIND_TIMEOBJ: stored_fld = stored_word[3*CRC_W-1:2*CRC_W];
      default:      stored_fld = '0;
    endcase

    if (apply_en) begin
      if (op_q == OP_CLEAR) begin
        do_clear     = 1'b1;
        res_status_c = ST_CLEARED;
        res_cnt_c    = vcount;
      end else begin
        if (op_q == OP_UPDATE || op_q == OP_VERIFY) res_calc_c = res_calc;
        if (!hit && !free_ok) begin
          res_status_c = ST_FULL;
        end else begin
          do_insert = ~hit;
          unique case (op_q)
            OP_UPDATE: begin
              do_write     = 1'b1;
              wval         = res_calc;
              res_status_c = ST_STORED;
            end
            OP_VERIFY: begin
              if (!hit || (kind_q == KIND_PLAYER && stored_fld == '0)) begin
                do_write     = 1'b1;
                wval         = res_calc;
                res_status_c = ST_BASELINE;
              end else begin
                res_exp_c    = stored_fld;
                res_status_c = (stored_fld == res_calc) ? ST_MATCH : ST_MISMATCH;
              end
            end
            OP_RESET: begin
              do_write     = 1'b1;
              wval         = '0;
              res_status_c = ST_RESET_DONE;
            end
            default: ;
          endcase
          // A new entry always gets its zeroed references written
          if (do_insert) do_write = 1'b1;
        end
      end
    end

    new_word = stored_word;
    if (wval != '0 || do_write) begin
      unique case (kind_q)
        KIND_PLAYER:  new_word[CRC_W-1:0]         = wval;
        KIND_TEXTOBJ: new_word[2*CRC_W-1:CRC_W]   = wval;
        KIND_TIMEOBJ: new_word[3*CRC_W-1:2*CRC_W] = wval;
        default:      ;
      endcase
    end
  end

  // Hold the result until the output register is free
  always_ff @(posedge clk) begin
    if (apply_en) begin
      res_status <= res_status_c;
      res_exp    <= res_exp_c;
      res_cnt    <= res_cnt_c;
    end
    if (apply_en) begin
      res_calc <= res_calc_c;
    end else if (in_word && s_axis_tlast) begin
      res_calc <= crc_final;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_en) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      m_axis_tdata <= {1'b0, res_cnt, res_calc, res_exp};
      m_axis_tuser <= res_status;
    end
  end

endmodule
`default_nettype wire
